// ===== hdl/radix_digit_emitter_defines.svh =====
// ---------------------------------------------------------------------------
// radix_digit_emitter_defines.svh
// assertion macros used by the checker file rde_checker.sv
// ---------------------------------------------------------------------------
`ifndef RADIX_DIGIT_EMITTER_DEFINES_SVH
`define RADIX_DIGIT_EMITTER_DEFINES_SVH

// property checked on every clock edge outside reset
`define RDE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define RDE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/rde_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rde_pkg
// types and constants shared by the radix digit emitter modules
// ---------------------------------------------------------------------------
package rde_pkg;

  // default upper bound on the minimum digit count
  localparam int MAX_DIGITS_DEF = 64;
  // digit store depth, enough for any 64-bit value in radix two
  localparam int STORE_DEPTH = 64;
  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  // bits of the value processed by the divider in one cycle
  localparam int DIV_BITS = 8;
  localparam int STEP_W = $clog2(64 / DIV_BITS);

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_RADIX    = 2'd0,
    CFG_ALPHA_LO = 2'd1,
    CFG_ALPHA_HI = 2'd2
  } cfg_idx_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    B_IDLE,
    B_CHECK,
    B_DIV,
    B_EMIT
  } back_state_t;

  // input item
  typedef struct packed {
    logic [63:0]        value;
    logic signed [7:0]  min_digits;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0] digit_char;
    logic       last;
    logic       empty_res;
  } out_item_t;

  // classified item held in the queue
  typedef struct packed {
    logic [63:0]      value;
    logic [CNT_W-1:0] min_count;
  } job_t;

  // handshake between front and back
  typedef struct packed {
    logic valid;
    job_t job;
  } job_chan_t;

endpackage

// ===== hdl/rde_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rde_front
// accepts items, clamps the minimum digit count and queues them
// ---------------------------------------------------------------------------
module rde_front #(
  parameter int MAX_DIGITS = rde_pkg::MAX_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rde_pkg::in_item_t   item,
  output rde_pkg::job_chan_t  chan,
  input  logic                job_pop
);

  localparam logic [7:0] MaxRaw = 8'(MAX_DIGITS);
  localparam logic [rde_pkg::CNT_W-1:0] MaxCnt = rde_pkg::CNT_W'(MAX_DIGITS);

  rde_pkg::job_t    q [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic [1:0]       fill_next;
  logic             accept;
  logic             pop;
  rde_pkg::job_t    job_in;

  // minimum count: negative means one digit, large values saturate
  always_comb begin
    job_in.value = item.value;
    if (item.min_digits[7]) begin
      job_in.min_count = rde_pkg::CNT_W'(1);
    end else if (item.min_digits > $signed(MaxRaw)) begin
      job_in.min_count = MaxCnt;
    end else begin
      job_in.min_count = item.min_digits[rde_pkg::CNT_W-1:0];
    end
  end

  // handshake
  assign busy   = (fill == 2'd2);
  assign accept = start && !busy;
  assign pop    = job_pop && (fill != 2'd0);

  always_comb begin
    fill_next = fill;
    if (accept && !pop) begin
      fill_next = fill + 2'd1;
    end else if (pop && !accept) begin
      fill_next = fill - 2'd1;
    end
  end

  // two-entry queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      fill <= fill_next;
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= job_in;
    end
  end

  assign chan.valid = (fill != 2'd0);
  assign chan.job   = q[rd_ptr];

endmodule

// ===== hdl/rde_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rde_back
// divides the value down into digits, then emits them most significant first,
// or one empty result when there are no digits
module rde_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [4:0]           radix_eff,
  input  logic [63:0]          alphabet_low,
  input  logic [63:0]          alphabet_high,
  input  rde_pkg::job_chan_t   chan,
  output logic                 job_pop,
  output logic                 strobe,
  output rde_pkg::out_item_t   result
);

  localparam int CW = rde_pkg::CNT_W;
  localparam int IW = rde_pkg::IDX_W;
  localparam int SW = rde_pkg::STEP_W;
  localparam logic [CW-1:0] Depth = CW'(rde_pkg::STORE_DEPTH);
  localparam logic [SW-1:0] LastStep = SW'((64 / rde_pkg::DIV_BITS) - 1);

  rde_pkg::back_state_t state;
  rde_pkg::back_state_t state_next;

  logic [63:0]   work;
  logic [CW-1:0] min_count;
  logic [CW-1:0] count;
  logic [3:0]    rem;
  logic [SW-1:0] step;
  logic [IW-1:0] rd_idx;
  logic [3:0]    rd_data;
  logic          s1_valid;
  logic          s1_last;
  logic [3:0]    store [rde_pkg::STORE_DEPTH];

  logic [63:0]   work_next;
  logic [3:0]    rem_next;
  logic          more;
  logic          st_wr;
  logic          rd_en;
  logic          empty_fire;
  logic [7:0]    char_sel;

  // one slice of restoring long division, several quotient bits a cycle
  always_comb begin
    logic [4:0]  t;
    logic [3:0]  r;
    logic [63:0] w;
    r = rem;
    w = work;
    for (int i = 0; i < rde_pkg::DIV_BITS; i++) begin
      t = {r, w[63]};
      if (t >= radix_eff) begin
        t = t - radix_eff;
        w = {w[62:0], 1'b1};
      end else begin
        w = {w[62:0], 1'b0};
      end
      r = t[3:0];
    end
    work_next = w;
    rem_next  = r;
  end

  // another digit is due
  assign more = ((work != 64'd0) || (count < min_count)) && (count < Depth);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rde_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and controls
  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    st_wr      = 1'b0;
    rd_en      = 1'b0;
    empty_fire = 1'b0;
    case (state)
      rde_pkg::B_IDLE: begin
        if (chan.valid) begin
          job_pop    = 1'b1;
          state_next = rde_pkg::B_CHECK;
        end
      end
      rde_pkg::B_CHECK: begin
        if (more) begin
          state_next = rde_pkg::B_DIV;
        end else if (count == '0) begin
          empty_fire = 1'b1;
          state_next = rde_pkg::B_IDLE;
        end else begin
          state_next = rde_pkg::B_EMIT;
        end
      end
      rde_pkg::B_DIV: begin
        if (step == LastStep) begin
          st_wr      = 1'b1;
          state_next = rde_pkg::B_CHECK;
        end
      end
      rde_pkg::B_EMIT: begin
        rd_en = 1'b1;
        if (rd_idx == '0) begin
          state_next = rde_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = rde_pkg::B_IDLE;
      end
    endcase
  end

  // conversion datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      work  <= 64'd0;
      count <= '0;
    end else begin
      if (job_pop) begin
        work      <= chan.job.value;
        min_count <= chan.job.min_count;
        count     <= '0;
      end
      if (state == rde_pkg::B_CHECK) begin
        rem    <= 4'd0;
        step   <= '0;
        rd_idx <= count[IW-1:0] - IW'(1);
      end
      if (state == rde_pkg::B_DIV) begin
        work <= work_next;
        rem  <= rem_next;
        step <= step + SW'(1);
        if (st_wr) begin
          count <= count + CW'(1);
        end
      end
      if (rd_en) begin
        rd_idx <= rd_idx - IW'(1);
      end
    end
  end

  // digit store, least significant digit at the lowest address
  always_ff @(posedge clk) begin
    if (st_wr) begin
      store[count[IW-1:0]] <= rem_next;
    end
    if (rd_en) begin
      rd_data <= store[rd_idx];
    end
  end

  // alphabet lookup of the digit read last cycle
  always_comb begin
    logic [63:0] word;
    word     = rd_data[3] ? alphabet_high : alphabet_low;
    char_sel = word[{rd_data[2:0], 3'b000} +: 8];
  end

  // read stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      s1_valid <= rd_en;
      strobe   <= s1_valid || empty_fire;
    end
    s1_last           <= rd_en && (rd_idx == '0);
    result.digit_char <= empty_fire ? 8'd0 : char_sel;
    result.last       <= empty_fire || s1_last;
    result.empty_res  <= empty_fire;
  end

endmodule

// ===== hdl/radix_digit_emitter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// radix_digit_emitter
// unsigned 64-bit value to digit characters in a radix from 2 to 16
// ---------------------------------------------------------------------------
// Usage: an item (value, min_digits) is taken at a clock edge with start high
// and busy low. The front end clamps min_digits and places the item in a
// two-entry queue; busy is high only while that queue is full.
// The back end converts one item at a time. Each digit takes a check and then
// a pass of the divider over all 64 bits of the value, which takes eight
// quotient bits per cycle. The digits then leave one per cycle, most
// significant first, each on result for one cycle with strobe high and
// last on the final one. An item's first result shows only after all of
// its digits have been divided. Value 0 with min_digits 0 gives one result
// with empty_res and last set and digit_char 0. Results cannot be held off
// by the receiver.
// Configuration (radix, alphabet_low, alphabet_high) is written through
// cfg_we / cfg_index / cfg_data; index 3 is ignored. The user must write it
// only while no conversion is pending; the block itself has no check for this.
// Reset (rst, synchronous) empties the queue, stops any conversion and sets
// radix 10 and both alphabet words to zero.
// ---------------------------------------------------------------------------
module radix_digit_emitter #(
  parameter int MAX_DIGITS = rde_pkg::MAX_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rde_pkg::in_item_t   item,
  output logic                strobe,
  output rde_pkg::out_item_t  result,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data
);

  logic [4:0]          radix;
  logic [4:0]          radix_eff;
  logic [63:0]         alphabet_low;
  logic [63:0]         alphabet_high;
  rde_pkg::job_chan_t  chan;
  logic                job_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix         <= 5'd10;
      alphabet_low  <= 64'd0;
      alphabet_high <= 64'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        rde_pkg::CFG_RADIX:    radix         <= cfg_data[4:0];
        rde_pkg::CFG_ALPHA_LO: alphabet_low  <= cfg_data;
        rde_pkg::CFG_ALPHA_HI: alphabet_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // radix held to the range two to sixteen
  always_comb begin
    if (radix < 5'd2) begin
      radix_eff = 5'd2;
    end else if (radix > 5'd16) begin
      radix_eff = 5'd16;
    end else begin
      radix_eff = radix;
    end
  end

  rde_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .chan    (chan),
    .job_pop (job_pop)
  );

  rde_back u_back (
    .clk           (clk),
    .rst           (rst),
    .radix_eff     (radix_eff),
    .alphabet_low  (alphabet_low),
    .alphabet_high (alphabet_high),
    .chan          (chan),
    .job_pop       (job_pop),
    .strobe        (strobe),
    .result        (result)
  );

endmodule

// ===== hdl/rde_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rde_checker
// port-level checks on the radix digit emitter, bound to the top level
// ---------------------------------------------------------------------------
`include "radix_digit_emitter_defines.svh"

module rde_checker (
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input logic               strobe,
  input rde_pkg::out_item_t result
);

  // an empty result is a lone final result with a zero character
  `RDE_ASSERT(a_empty_form,
              strobe && result.empty_res |-> result.last && (result.digit_char == 8'd0),
              "empty result not final or not zero")

  // digits of one item leave on consecutive cycles
  `RDE_ASSERT(a_digits_back_to_back, strobe && !result.last |=> strobe,
              "gap inside a digit run")

  // nothing follows an empty result in the next cycle
  `RDE_ASSERT(a_empty_alone, strobe && result.empty_res |=> !strobe,
              "result right after an empty result")

  // reset leaves the block ready and silent
  `RDE_ASSERT_ALWAYS(a_reset_quiet, rst |=> !busy && !strobe,
                     "busy or strobe after reset")

endmodule

bind radix_digit_emitter rde_checker u_rde_checker (
  .clk    (clk),
  .rst    (rst),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for radix_digit_emitter: drives conversion items and
// register writes, predicts every digit character and compares each strobed
// result in order against the predicted digit stream
// ---------------------------------------------------------------------------
module tb;

  localparam int DIGIT_LIMIT    = rde_pkg::MAX_DIGITS_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 40;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 38;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // digit prediction and in-order comparison of results
  class digit_scoreboard;
    logic [4:0]         radix_reg;
    logic [63:0]        alpha_lo;
    logic [63:0]        alpha_hi;
    rde_pkg::out_item_t expected_digits[$];
    int                 errors;

    function new();
      radix_reg = 5'd10;
      alpha_lo  = '0;
      alpha_hi  = '0;
      errors    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        rde_pkg::CFG_RADIX:    radix_reg = data[4:0];
        rde_pkg::CFG_ALPHA_LO: alpha_lo  = data;
        rde_pkg::CFG_ALPHA_HI: alpha_hi  = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] char_of_digit(logic [3:0] d);
      logic [63:0] word;
      word = d[3] ? alpha_hi : alpha_lo;
      return word[d[2:0]*8 +: 8];
    endfunction

    function int pending();
      return expected_digits.size();
    endfunction

    // convert one accepted item into its expected digit stream
    function void note_item(rde_pkg::in_item_t it);
      logic [63:0]        work;
      logic [63:0]        base;
      logic [7:0]         raw;
      logic [3:0]         digs [rde_pkg::STORE_DEPTH];
      int                 min_count;
      int                 n;
      int                 k;
      rde_pkg::out_item_t res;
      base = 64'(radix_reg);
      if (base < 2) base = 2;
      if (base > 16) base = 16;
      raw = it.min_digits;
      // negative minimum means at least one digit, large minimum saturates
      if (raw[7]) min_count = 1;
      else if (int'(raw) > DIGIT_LIMIT) min_count = DIGIT_LIMIT;
      else min_count = int'(raw);
      work = it.value;
      n = 0;
      while ((work != 0 || n < min_count) && n < rde_pkg::STORE_DEPTH) begin
        digs[n] = 4'(work % base);
        work = work / base;
        n++;
      end
      // zero value with zero minimum gives a single empty result
      if (n == 0) begin
        res.digit_char = 8'h00;
        res.last = 1'b1;
        res.empty_res = 1'b1;
        expected_digits.push_back(res);
      end else begin
        for (k = 0; k < n; k++) begin
          res.digit_char = char_of_digit(digs[n - 1 - k]);
          res.last = (k == n - 1);
          res.empty_res = 1'b0;
          expected_digits.push_back(res);
        end
      end
    endfunction

    function void check_result(rde_pkg::out_item_t got);
      rde_pkg::out_item_t want;
      if (expected_digits.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual char %h last %b empty %b",
                 $time, got.digit_char, got.last, got.empty_res);
        errors++;
        return;
      end
      want = expected_digits.pop_front();
      if (got.digit_char !== want.digit_char) begin
        $display("%0t: digit_char mismatch: expected %h actual %h",
                 $time, want.digit_char, got.digit_char);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch: expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
      if (got.empty_res !== want.empty_res) begin
        $display("%0t: empty_res mismatch: expected %b actual %b",
                 $time, want.empty_res, got.empty_res);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  rde_pkg::in_item_t  item;
  logic               strobe;
  rde_pkg::out_item_t result;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [63:0]        cfg_data;

  digit_scoreboard sb;
  int idle_pct;
  int stall_cycles;

  radix_digit_emitter dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .strobe    (strobe),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // monitor: note accepted items, check results, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_item(item);
      if (strobe) sb.check_result(result);
      if ((start && !busy) || strobe) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic rde_pkg::in_item_t random_item();
    rde_pkg::in_item_t it;
    logic [31:0]       rnd;
    int                sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: it.value = '0;
      1: it.value = '1;
      2: it.value = 64'd1 << $urandom_range(0, 63);
      3, 4, 5: it.value = {$urandom, $urandom} >> $urandom_range(0, 63);
      default: it.value = {$urandom, $urandom};
    endcase
    rnd = $urandom;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3, 4, 5: it.min_digits = 8'($urandom_range(0, 8));
      6: it.min_digits = -8'sd1;
      7: it.min_digits = 8'($urandom_range(60, 127));
      default: it.min_digits = rnd[7:0];
    endcase
    return it;
  endfunction

  // one register write; the caller lowers cfg_we after its last write
  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic load_config(logic [63:0] radix_word, logic [63:0] lo, logic [63:0] hi,
                             bit with_unused);
    write_reg(rde_pkg::CFG_RADIX, radix_word);
    write_reg(rde_pkg::CFG_ALPHA_LO, lo);
    write_reg(rde_pkg::CFG_ALPHA_HI, hi);
    if (with_unused) write_reg(CFG_UNUSED, {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  // optional random gap, then hold the item until it is taken
  task automatic send_item(rde_pkg::in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      item <= random_item();
      @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic send(logic [63:0] value, logic signed [7:0] min_digits);
    rde_pkg::in_item_t it;
    it.value = value;
    it.min_digits = min_digits;
    send_item(it);
  endtask

  // drain all outstanding digits before touching registers; the extra edge
  // lets the monitor note the item taken at the edge just passed
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    // reset settings: radix ten, all characters zero
    send(64'd0, 8'sd0);
    send(64'd12345, 8'sd0);
    send('1, -8'sd1);
    wait_idle();
    // hex with ascii alphabet, plus an ignored write to the spare index
    load_config(64'd16, 64'h3736353433323130, 64'h6665646362613938, 1'b1);
    send(64'd0, 8'sd0);
    send(64'd0, -8'sd1);
    send(64'd0, -8'sd128);
    send(64'd0, 8'sd64);
    send(64'd0, 8'sd127);
    send('1, 8'sd0);
    send('1, 8'sd20);
    send(64'd1, 8'sd65);
    send(64'h8000000000000000, 8'sd1);
    send(64'h0123456789abcdef, 8'sd8);
    wait_idle();
    // binary, the longest conversions
    load_config(64'd2, 64'h3736353433323130, 64'h6665646362613938, 1'b0);
    send('1, 8'sd0);
    send(64'd1, 8'sd0);
    send(64'd5, 8'sd70);
    wait_idle();
    // radix below two acts as two
    load_config(64'd0, 64'h3736353433323130, 64'h6665646362613938, 1'b0);
    send(64'd6, 8'sd3);
    wait_idle();
    load_config(64'd1, 64'h3736353433323130, 64'h6665646362613938, 1'b0);
    send(64'd7, 8'sd0);
    wait_idle();
    // radix above sixteen acts as sixteen
    load_config(64'd17, 64'h3736353433323130, 64'h6665646362613938, 1'b0);
    send(64'd255, 8'sd2);
    wait_idle();
    load_config({59'h7ffffffffffffff, 5'd31}, 64'h3736353433323130, 64'h6665646362613938,
                1'b0);
    send(64'd255, 8'sd2);
    wait_idle();
    // other radices: three and ten
    load_config(64'd3, 64'h3736353433323130, 64'h6665646362613938, 1'b0);
    send('1, -8'sd1);
    wait_idle();
    load_config(64'd10, 64'h3736353433323130, 64'h6665646362613938, 1'b0);
    send('1, 8'sd0);
    wait_idle();
  endtask

  task automatic run_random();
    logic [63:0] radix_word;
    logic [63:0] lo;
    logic [63:0] hi;
    int          p;
    int          i;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      radix_word = {$urandom, $urandom};
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      case (p)
        0: radix_word[4:0] = 5'd2;
        1: radix_word[4:0] = 5'd16;
        default: begin
          if ($urandom_range(0, 3) == 0) radix_word[4:0] = 5'($urandom_range(0, 31));
          else radix_word[4:0] = 5'($urandom_range(2, 16));
        end
      endcase
      // extreme alphabets in two phases
      if (p == 1) begin
        lo = '1;
        hi = '0;
      end
      if (p == 4) begin
        lo = '0;
        hi = '1;
      end
      // one phase with no gaps at all
      idle_pct = (p == 3) ? 0 : 12;
      load_config(radix_word, lo, hi, ($urandom_range(0, 1) == 1));
      for (i = 0; i < PHASE_ITEMS; i++) send_item(random_item());
      wait_idle();
    end
  endtask

  // stimulus
  initial begin
    sb = new();
    idle_pct = 12;
    stall_cycles = 0;
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= rde_pkg::CFG_RADIX;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/rde_pkg.sv
hdl/rde_front.sv
hdl/rde_back.sv
hdl/radix_digit_emitter.sv
hdl/rde_checker.sv
verif/tb.sv
